// ===== design/eu_dst_utc_offset_macros.svh =====
// Assertion macros shared by the eu_dst_utc_offset checkers.
`ifndef EU_DST_UTC_OFFSET_MACROS_SVH
`define EU_DST_UTC_OFFSET_MACROS_SVH

// Same-cycle implication, held off during reset.
`define EUDST_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eu_dst_utc_offset: implication check failed");

// Next-cycle implication, held off during reset.
`define EUDST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eu_dst_utc_offset: next-cycle check failed");

`endif

// ===== design/eudst_pkg.sv =====
// Package: types and constants of the EU summer time offset block.
`timescale 1ns / 1ps
package eudst_pkg;

  localparam int unsigned EpochW   = 32;
  localparam int unsigned OffsetW  = 13;
  localparam int unsigned InstW    = 25;  // seconds within a year
  localparam int unsigned DoyW     = 9;   // day of year

  localparam logic [InstW-1:0] DAY_SEC     = 25'd86400;
  localparam logic [InstW-1:0] SWITCH_SEC  = 25'd3600;
  localparam logic [InstW-1:0] YEAR_SEC    = 25'd31536000;  // 365 days
  localparam logic [InstW-1:0] LEAP_SEC    = 25'd31622400;  // 366 days

  localparam logic [OffsetW-1:0] OFFSET_WINTER = 13'd3600;
  localparam logic [OffsetW-1:0] OFFSET_SUMMER = 13'd7200;

  // Year-start phase for 1970
  localparam logic [1:0] MOD4_1970   = 2'd2;
  localparam logic [6:0] MOD100_1970 = 7'd70;
  localparam logic [8:0] MOD400_1970 = 9'd370;
  localparam logic [2:0] WDAY_1970   = 3'd4;  // 1970-01-01 was a Thursday

  // Day of year (from 0) of the last day of March / October, common year
  localparam logic [DoyW-1:0] MAR_LAST_DOY = 9'd89;
  localparam logic [DoyW-1:0] OCT_LAST_DOY = 9'd303;
  // The same values mod 7
  localparam logic [2:0] MAR_LAST_MOD7 = 3'd5;
  localparam logic [2:0] OCT_LAST_MOD7 = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MUL_MAR,
    ST_CMP_MAR,
    ST_MUL_OCT,
    ST_CMP_OCT
  } state_t;

  typedef struct packed {
    logic init;  // load 1970 phase
    logic step;  // advance one year
  } cal_ctrl_t;

  typedef struct packed {
    logic       leap;
    logic [2:0] wday;  // weekday of Jan 1, 0 = Sunday
  } cal_status_t;

endpackage

// ===== design/eudst_cal.sv =====
// Year calendar tracker: leap phase and weekday of January 1.
`timescale 1ns / 1ps
module eudst_cal
  import eudst_pkg::*;
(
  input  logic        clk,
  input  cal_ctrl_t   ctrl,
  output cal_status_t status
);

  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;
  logic [2:0] wday;
  logic       leap;
  logic [3:0] wsum;

  assign leap = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign wsum = {1'b0, wday} + (leap ? 4'd2 : 4'd1);

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      mod4   <= MOD4_1970;
      mod100 <= MOD100_1970;
      mod400 <= MOD400_1970;
      wday   <= WDAY_1970;
    end else if (ctrl.step) begin
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
      wday   <= (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
    end
  end

  assign status.leap = leap;
  assign status.wday = wday;

endmodule

// ===== design/eudst_alu.sv =====
// Shared subtract/compare unit.
`timescale 1ns / 1ps
module eudst_alu
  import eudst_pkg::*;
(
  input  logic [EpochW-1:0] a,
  input  logic [EpochW-1:0] b,
  output logic [EpochW-1:0] diff,
  output logic              borrow  // a < b
);

  logic [EpochW:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[EpochW-1:0];
  assign borrow = full[EpochW];

endmodule

// ===== design/eu_dst_utc_offset.sv =====
// Top level: CET/CEST offset from a UTC epoch second count.
`timescale 1ns / 1ps
// Sequence: after the accepting edge the year search walks one year per cycle
//   through the shared subtractor over the whole years since 1970 (0..136), then two
//   multiply/compare pairs follow; done is registered from the last compare.
// A new word is accepted only while idle; busy is low in the done cycle.
// Reset (rst, synchronous, active high) returns the sequencer to idle and clears done.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module eu_dst_utc_offset
  import eudst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [EpochW-1:0]  epoch_utc,
  output logic               done,
  output logic [OffsetW-1:0] utc_offset_seconds,
  output logic               in_summer_time
);

  state_t state, state_next;

  // rem: seconds left after whole years are stripped, i.e. time within year
  logic [EpochW-1:0] rem, rem_next;
  // off: switch instant within the year, seconds
  logic [InstW-1:0]  off, off_next;
  logic              ge_start, ge_start_next;
  logic              done_next;
  logic [OffsetW-1:0] offset_next;
  logic              summer_next;

  cal_ctrl_t   cal_ctrl;
  cal_status_t cal_st;

  logic [EpochW-1:0] alu_b;
  logic [EpochW-1:0] alu_diff;
  logic              alu_borrow;

  // Last Sunday of the month selected by the sequencer
  logic              sel_oct;
  logic [DoyW-1:0]   last_doy;
  logic [3:0]        dsum;
  logic [2:0]        dow;
  logic [DoyW-1:0]   sunday_doy;
  logic [InstW-1:0]  switch_inst;

  eudst_cal u_cal (
    .clk    (clk),
    .ctrl   (cal_ctrl),
    .status (cal_st)
  );

  eudst_alu u_alu (
    .a      (rem),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // Weekday of the month's last day = Jan 1 weekday + day of year, mod 7.
  assign sel_oct  = (state == ST_MUL_OCT);
  assign last_doy = (sel_oct ? OCT_LAST_DOY : MAR_LAST_DOY) + DoyW'(cal_st.leap);
  assign dsum     = {1'b0, cal_st.wday}
                  + {1'b0, sel_oct ? OCT_LAST_MOD7 : MAR_LAST_MOD7}
                  + 4'(cal_st.leap);
  assign dow      = (dsum >= 4'd7) ? 3'(dsum - 4'd7) : dsum[2:0];
  assign sunday_doy = last_doy - DoyW'(dow);
  // Switch at 01:00 UTC on that Sunday
  assign switch_inst = InstW'(InstW'(sunday_doy) * DAY_SEC) + SWITCH_SEC;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    rem                <= rem_next;
    off                <= off_next;
    ge_start           <= ge_start_next;
    utc_offset_seconds <= offset_next;
    in_summer_time     <= summer_next;
  end

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    off_next      = off;
    ge_start_next = ge_start;
    done_next     = 1'b0;
    offset_next   = utc_offset_seconds;
    summer_next   = in_summer_time;
    cal_ctrl      = '0;
    alu_b         = EpochW'(off);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          rem_next      = epoch_utc;
          cal_ctrl.init = 1'b1;
          state_next    = ST_YEAR;
        end
      end
      ST_YEAR: begin
        // strip one whole year per cycle
        alu_b = EpochW'(cal_st.leap ? LEAP_SEC : YEAR_SEC);
        if (alu_borrow) begin
          state_next = ST_MUL_MAR;
        end else begin
          rem_next      = alu_diff;
          cal_ctrl.step = 1'b1;
        end
      end
      ST_MUL_MAR: begin
        off_next   = switch_inst;
        state_next = ST_CMP_MAR;
      end
      ST_CMP_MAR: begin
        ge_start_next = !alu_borrow;
        state_next    = ST_MUL_OCT;
      end
      ST_MUL_OCT: begin
        off_next   = switch_inst;
        state_next = ST_CMP_OCT;
      end
      ST_CMP_OCT: begin
        // summer from March instant up to, not including, October instant
        summer_next = ge_start && alu_borrow;
        offset_next = (ge_start && alu_borrow) ? OFFSET_SUMMER : OFFSET_WINTER;
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== design/eudst_checker.sv =====
// Port-level checker for eu_dst_utc_offset, with its bind.
`timescale 1ns / 1ps
`include "eu_dst_utc_offset_macros.svh"
module eudst_checker
  import eudst_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [OffsetW-1:0] utc_offset_seconds,
  input logic               in_summer_time
);

  `EUDST_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done)
  `EUDST_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `EUDST_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `EUDST_ASSERT_IMPLY(a_summer_val, clk, rst, done && in_summer_time, utc_offset_seconds == OFFSET_SUMMER)
  `EUDST_ASSERT_IMPLY(a_winter_val, clk, rst, done && !in_summer_time, utc_offset_seconds == OFFSET_WINTER)

endmodule

bind eu_dst_utc_offset eudst_checker u_eudst_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .done               (done),
  .utc_offset_seconds (utc_offset_seconds),
  .in_summer_time     (in_summer_time)
);
